@@ design/hcr_pkg.sv @@
// Shared types, codes and result builders for the HEVC configuration record parser.
// No dependencies; used by every module of the block.
package hcr_pkg;

  localparam int unsigned MaxResults = 4;
  localparam logic [4:0] MinRecordLastIdx = 5'd22;  // index of the 23rd record byte

  typedef enum logic [2:0] {
    PH_HEADER   = 3'd0,
    PH_ARR_TYPE = 3'd1,
    PH_NUM_HI   = 3'd2,
    PH_NUM_LO   = 3'd3,
    PH_LEN_HI   = 3'd4,
    PH_LEN_LO   = 3'd5,
    PH_PAYLOAD  = 3'd6,
    PH_DONE     = 3'd7
  } phase_t;

  localparam logic [1:0] KIND_FIELD   = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_STATUS  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_TRUNC = 2'd2;

  localparam logic [1:0] CLASS_OTHER = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  field_id;
    logic [47:0] field_value;
    logic [1:0]  set_class;
    logic [7:0]  payload_byte;
    logic        unit_first;
    logic        unit_last;
    logic [1:0]  status;
    logic        last_of_run;
  } res_t;

  typedef struct packed {
    res_t [MaxResults-1:0] res;
    logic [2:0]            count;
  } batch_t;

  function automatic res_t mk_field(logic [4:0] id, logic [47:0] val);
    res_t r;
    r             = '0;
    r.kind        = KIND_FIELD;
    r.field_id    = id;
    r.field_value = val;
    return r;
  endfunction

  function automatic res_t mk_status(logic [1:0] st);
    res_t r;
    r        = '0;
    r.kind   = KIND_STATUS;
    r.status = st;
    return r;
  endfunction

  function automatic res_t mk_payload(logic [1:0] cls, logic [7:0] b, logic first,
                                      logic last);
    res_t r;
    r              = '0;
    r.kind         = KIND_PAYLOAD;
    r.set_class    = cls;
    r.payload_byte = b;
    r.unit_first   = first;
    r.unit_last    = last;
    return r;
  endfunction

  // Append one result; drop it when the batch is already full.
  function automatic batch_t push_res(batch_t bt, res_t r);
    batch_t o;
    o = bt;
    if (bt.count < 3'(MaxResults)) begin
      o.res[bt.count[1:0]] = r;
      o.count              = bt.count + 3'd1;
    end
    return o;
  endfunction

endpackage

@@ design/hevc_config_record_parser.sv @@
// Top level of the HEVC decoder configuration record parser.
// Depends on hcr_pkg, hcr_parse and hcr_out_buf.
//
// Usage:
//   Input stream: one record byte per beat on in_tdata[7:0]; in_tlast marks the
//   last byte of the supplied buffer and closes the record (status is reported,
//   then the parser starts over on the next byte).
//   Output stream: one result per beat. out_tuser is the result kind (header
//   field, parameter-set payload byte, record status); out_tlast marks the final
//   result caused by one input byte. Bytes that cause no result give no beat.
//   The results of a byte are presented from the result register, which takes
//   the byte's batch from the input register once the result register is free.
//   Throughput: one byte per cycle while each byte causes at most one result
//   and the receiver takes every beat. A byte causing several results holds
//   the result register, and the next byte waits, until its last result is
//   taken; only header bytes 2 and 22, a payload byte that completes the record
//   and an end byte that adds a status to other results give more than one result.
//   Receiver stall: held results stay on the port; the input register fills and
//   in_tready drops until the result register drains.
//   Reset (rst_n low, synchronous): parser returns to the header phase and all
//   held bytes and results are discarded.
module hevc_config_record_parser
  import hcr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,   // end_of_buffer
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [4:0] field_id, [52:5] field_value, [54:53] set_class,
                                  // [62:55] payload_byte, [63] unit_first, [64] unit_last,
                                  // [66:65] status, [71:67] zero
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast   // last_of_run
);

  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_end_r;
  logic       buf_free;
  logic       advance;
  batch_t     batch;
  res_t       res;

  assign advance   = in_vld_r && buf_free;
  assign in_tready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_end_r  <= in_tlast;
    end
  end

  hcr_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .item_byte (in_byte_r),
    .item_end  (in_end_r),
    .batch     (batch)
  );

  hcr_out_buf u_out_buf (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (advance),
    .batch   (batch),
    .free    (buf_free),
    .res_vld (out_tvalid),
    .res_rdy (out_tready),
    .res     (res)
  );

  assign out_tdata = {5'd0, res.status, res.unit_last, res.unit_first, res.payload_byte,
                      res.set_class, res.field_value, res.field_id};
  assign out_tuser = res.kind;
  assign out_tlast = res.last_of_run;

endmodule

@@ design/hcr_parse.sv @@
// Record parser state and single-step logic: one byte in, a batch of up to four results out.
// Depends on hcr_pkg.
module hcr_parse
  import hcr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] item_byte,
  input  logic       item_end,
  output batch_t     batch
);

  phase_t      phase_r, phase_nxt;
  logic [4:0]  byte_count_r, byte_count_nxt;
  logic [47:0] field_accum_r, field_accum_nxt;
  logic [7:0]  arrays_left_r, arrays_left_nxt;
  logic [15:0] units_left_r, units_left_nxt;
  logic [15:0] unit_bytes_left_r, unit_bytes_left_nxt;
  logic [1:0]  cur_class_r, cur_class_nxt;
  logic [7:0]  high_len_r, high_len_nxt;
  logic        first_pend_r, first_pend_nxt;

  always_comb begin
    batch_t      bt;
    logic        done_now;
    logic        pay_last;
    logic        do_reset;
    logic [47:0] acc;
    logic [5:0]  t;
    logic [7:0]  arr_dec;
    logic [15:0] unit_dec;
    logic [15:0] len;

    bt                  = '0;
    done_now            = 1'b0;
    pay_last            = 1'b0;
    do_reset            = 1'b0;
    acc                 = {field_accum_r[39:0], item_byte};
    t                   = item_byte[5:0];
    arr_dec             = arrays_left_r - 8'd1;
    unit_dec            = units_left_r - 16'd1;
    len                 = {high_len_r, item_byte};
    phase_nxt           = phase_r;
    byte_count_nxt      = byte_count_r;
    field_accum_nxt     = field_accum_r;
    arrays_left_nxt     = arrays_left_r;
    units_left_nxt      = units_left_r;
    unit_bytes_left_nxt = unit_bytes_left_r;
    cur_class_nxt       = cur_class_r;
    high_len_nxt        = high_len_r;
    first_pend_nxt      = first_pend_r;

    case (phase_r)
      PH_HEADER: begin
        if (item_end && byte_count_r < MinRecordLastIdx) begin
          bt       = push_res(bt, mk_status(ST_SHORT));
          do_reset = 1'b1;
        end else begin
          field_accum_nxt = acc;
          // byte positions within the fixed part of the record
          case (byte_count_r)
            5'd0: bt = push_res(bt, mk_field(5'd0, {40'd0, item_byte}));
            5'd1: begin
              bt = push_res(bt, mk_field(5'd1, {46'd0, item_byte[7:6]}));
              bt = push_res(bt, mk_field(5'd2, {47'd0, item_byte[5]}));
              bt = push_res(bt, mk_field(5'd3, {43'd0, item_byte[4:0]}));
            end
            5'd5:  bt = push_res(bt, mk_field(5'd4, {16'd0, acc[31:0]}));
            5'd11: bt = push_res(bt, mk_field(5'd5, acc));
            5'd12: bt = push_res(bt, mk_field(5'd6, {40'd0, item_byte}));
            5'd14: bt = push_res(bt, mk_field(5'd7, {36'd0, acc[11:0]}));
            5'd15: bt = push_res(bt, mk_field(5'd8, {46'd0, item_byte[1:0]}));
            5'd16: bt = push_res(bt, mk_field(5'd9, {46'd0, item_byte[1:0]}));
            5'd17: bt = push_res(bt, mk_field(5'd10, {45'd0, item_byte[2:0]}));
            5'd18: bt = push_res(bt, mk_field(5'd11, {45'd0, item_byte[2:0]}));
            5'd20: bt = push_res(bt, mk_field(5'd12, {32'd0, acc[15:0]}));
            5'd21: begin
              bt = push_res(bt, mk_field(5'd13, {46'd0, item_byte[7:6]}));
              bt = push_res(bt, mk_field(5'd14, {45'd0, item_byte[5:3]}));
              bt = push_res(bt, mk_field(5'd15, {47'd0, item_byte[2]}));
              bt = push_res(bt, mk_field(5'd16, {46'd0, item_byte[1:0]}));
            end
            5'd22: begin
              arrays_left_nxt = item_byte;
              field_accum_nxt = '0;
              if (item_byte == 8'd0) begin
                done_now = 1'b1;
              end else begin
                phase_nxt = PH_ARR_TYPE;
              end
            end
            default: ;
          endcase
          if (bt.count != 3'd0) begin
            field_accum_nxt = '0;
          end
          if (byte_count_r != 5'd31) begin
            byte_count_nxt = byte_count_r + 5'd1;
          end
        end
      end
      PH_ARR_TYPE: begin
        if (t inside {[6'd32:6'd34]}) begin
          cur_class_nxt = 2'(t - 6'd32);
        end else begin
          cur_class_nxt = CLASS_OTHER;
        end
        phase_nxt = PH_NUM_HI;
      end
      PH_NUM_HI: begin
        high_len_nxt = item_byte;
        phase_nxt    = PH_NUM_LO;
      end
      PH_NUM_LO: begin
        units_left_nxt = len;
        if (len == 16'd0) begin
          arrays_left_nxt = arr_dec;
          if (arr_dec == 8'd0) done_now = 1'b1;
          else                 phase_nxt = PH_ARR_TYPE;
        end else begin
          phase_nxt = PH_LEN_HI;
        end
      end
      PH_LEN_HI: begin
        high_len_nxt = item_byte;
        phase_nxt    = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        unit_bytes_left_nxt = len;
        if (len == 16'd0) begin
          units_left_nxt = unit_dec;
          if (unit_dec == 16'd0) begin
            arrays_left_nxt = arr_dec;
            if (arr_dec == 8'd0) done_now = 1'b1;
            else                 phase_nxt = PH_ARR_TYPE;
          end else begin
            phase_nxt = PH_LEN_HI;
          end
        end else begin
          phase_nxt      = PH_PAYLOAD;
          first_pend_nxt = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        pay_last = (unit_bytes_left_r <= 16'd1);
        if (cur_class_r != CLASS_OTHER) begin
          bt = push_res(bt, mk_payload(cur_class_r, item_byte, first_pend_r, pay_last));
        end
        first_pend_nxt      = 1'b0;
        unit_bytes_left_nxt = pay_last ? 16'd0 : unit_bytes_left_r - 16'd1;
        if (pay_last) begin
          units_left_nxt = unit_dec;
          if (unit_dec == 16'd0) begin
            arrays_left_nxt = arr_dec;
            if (arr_dec == 8'd0) done_now = 1'b1;
            else                 phase_nxt = PH_ARR_TYPE;
          end else begin
            phase_nxt = PH_LEN_HI;
          end
        end
      end
      default: ;
    endcase

    if (!do_reset) begin
      if (done_now) begin
        bt        = push_res(bt, mk_status(ST_OK));
        phase_nxt = PH_DONE;
      end
      if (item_end) begin
        if (phase_nxt != PH_DONE) begin
          bt = push_res(bt, mk_status(ST_TRUNC));
        end
        do_reset = 1'b1;
      end
    end

    if (do_reset) begin
      phase_nxt           = PH_HEADER;
      byte_count_nxt      = '0;
      field_accum_nxt     = '0;
      arrays_left_nxt     = '0;
      units_left_nxt      = '0;
      unit_bytes_left_nxt = '0;
      cur_class_nxt       = '0;
      high_len_nxt        = '0;
      first_pend_nxt      = 1'b0;
    end

    // mark the final result of this byte
    if (bt.count != 3'd0) begin
      bt.res[2'(bt.count - 3'd1)].last_of_run = 1'b1;
    end
    batch = bt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r           <= PH_HEADER;
      byte_count_r      <= '0;
      field_accum_r     <= '0;
      arrays_left_r     <= '0;
      units_left_r      <= '0;
      unit_bytes_left_r <= '0;
      cur_class_r       <= '0;
      high_len_r        <= '0;
      first_pend_r      <= 1'b0;
    end else if (step) begin
      phase_r           <= phase_nxt;
      byte_count_r      <= byte_count_nxt;
      field_accum_r     <= field_accum_nxt;
      arrays_left_r     <= arrays_left_nxt;
      units_left_r      <= units_left_nxt;
      unit_bytes_left_r <= unit_bytes_left_nxt;
      cur_class_r       <= cur_class_nxt;
      high_len_r        <= high_len_nxt;
      first_pend_r      <= first_pend_nxt;
    end
  end

endmodule

@@ design/hcr_out_buf.sv @@
// Result register: holds one batch of up to four results and hands them out one beat at a time.
// Depends on hcr_pkg.
module hcr_out_buf
  import hcr_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   load,
  input  batch_t batch,
  output logic   free,
  output logic   res_vld,
  input  logic   res_rdy,
  output res_t   res
);

  res_t [MaxResults-1:0] res_r;
  logic [1:0]            rd_idx_r, rd_idx_nxt;
  logic [2:0]            cnt_r, cnt_nxt;

  assign res_vld = (cnt_r != 3'd0);
  assign res     = res_r[rd_idx_r];
  // free when empty, or when the last held beat leaves this cycle
  assign free    = (cnt_r == 3'd0) || (cnt_r == 3'd1 && res_rdy);

  always_comb begin
    rd_idx_nxt = rd_idx_r;
    cnt_nxt    = cnt_r;
    if (load) begin
      rd_idx_nxt = '0;
      cnt_nxt    = batch.count;
    end else if (res_vld && res_rdy) begin
      rd_idx_nxt = rd_idx_r + 2'd1;
      cnt_nxt    = cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r <= '0;
      cnt_r    <= '0;
    end else begin
      rd_idx_r <= rd_idx_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= batch.res;
    end
  end

endmodule
